>>> src/fl32_pkg.sv
// shared types, constants and the fold function for the fletcher-32 checksum core
package fl32_pkg;

  localparam int unsigned SumW  = 32;
  localparam int unsigned WordW = 16;
  localparam logic [SumW-1:0] SumInit = 32'h0000_ffff;

  // first-sum results handed from the input stage to the second-sum stage
  typedef struct packed {
    logic [SumW-1:0] sum1_raw;    // first sum after this word, before any fold
    logic [SumW-1:0] sum1_final;  // first sum after the final fold (last item only)
    logic            fold_blk;    // block or message-end fold applies on this word
    logic            last;        // final word of the message
  } stage_t;

  // (s & 0xffff) + (s >>> 16), wrapping at 32 bits
  function automatic logic [SumW-1:0] fold(input logic [SumW-1:0] s);
    logic [SumW-1:0] lo;
    logic [SumW-1:0] hi;
    lo = {16'h0000, s[15:0]};
    hi = {{16{s[31]}}, s[31:16]};
    return lo + hi;
  endfunction

endpackage

>>> src/fl32_sum2_stage.sv
// second-sum accumulator and registered checksum output
module fl32_sum2_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 b_valid,
  input  fl32_pkg::stage_t     b,
  output logic                 b_take,
  output logic [31:0]          checksum,
  output logic                 out_valid,
  input  logic                 out_ready
);
  import fl32_pkg::*;

  logic [SumW-1:0] sum2;
  logic [SumW-1:0] sum2_next;
  logic [SumW-1:0] sum2_raw;
  logic [SumW-1:0] sum2_blk;
  logic [SumW-1:0] sum2_final;

  // a non-last item always moves; a last item needs room in the output register
  assign b_take = b_valid && (!b.last || !out_valid || out_ready);

  // second sum update with optional block fold and final fold
  always_comb begin
    sum2_raw   = sum2 + b.sum1_raw;
    sum2_blk   = b.fold_blk ? fold(sum2_raw) : sum2_raw;
    sum2_final = fold(sum2_blk);
    sum2_next  = b.last ? SumInit : sum2_blk;
  end

  // second sum register
  always_ff @(posedge clk) begin
    if (rst) begin
      sum2 <= SumInit;
    end else if (b_take) begin
      sum2 <= sum2_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_take && b.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take && b.last) begin
      checksum <= {sum2_final[15:0], 16'h0000} | b.sum1_final;
    end
  end

endmodule

>>> src/fletcher32_signed_word_checksum_core.sv
// top level of the fletcher-32 checksum core over signed 16-bit words
//
// Input channel: word (signed 16 bits) and last, with in_valid / in_ready.
// Output channel: checksum (32 bits) with out_valid / out_ready; one item
// leaves for each input item that has last set, none for the others.
// Each accepted word updates the first sum and its final fold, the block
// word count and the block fold at once; from the stage register the second
// sum and its final fold are done and, for a last word, the checksum is
// loaded into the output register.
// Throughput is one word per cycle while no last word waits for the output
// register; the second-sum loop sits behind the first-sum loop.
// A finished checksum waiting in the output register does not stop input:
// further non-last words keep flowing; only a second last word waits for
// the output register to empty, which then backs up in_ready.
// Reset (rst, synchronous) sets both sums to 0xffff, clears the block count
// and empties the pipeline and the output register.
module fletcher32_signed_word_checksum_core #(
  parameter int unsigned BLOCK_WORDS = 360
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [15:0] word,
  input  logic               last,
  input  logic               in_valid,
  output logic               in_ready,
  output logic [31:0]        checksum,
  output logic               out_valid,
  input  logic               out_ready
);
  import fl32_pkg::*;

  localparam int unsigned CntW = $clog2(BLOCK_WORDS + 1);

  logic [SumW-1:0] sum1;
  logic [SumW-1:0] sum1_next;
  logic [SumW-1:0] sum1_raw;
  logic [SumW-1:0] sum1_blk;
  logic [CntW-1:0] block_count;
  logic [CntW-1:0] block_count_next;
  logic [CntW-1:0] cnt_inc;
  logic            fold_blk;
  logic            in_take;
  logic            b_valid;
  logic            b_take;
  stage_t          b;
  stage_t          b_next;

  assign in_ready = !b_valid || b_take;
  assign in_take  = in_valid && in_ready;

  // first sum, block count and block fold for the incoming word
  always_comb begin
    cnt_inc  = block_count + CntW'(1);
    fold_blk = (cnt_inc >= CntW'(BLOCK_WORDS)) || last;
    sum1_raw = sum1 + {{(SumW-WordW){word[WordW-1]}}, word};
    sum1_blk = fold_blk ? fold(sum1_raw) : sum1_raw;
    sum1_next        = last ? SumInit : sum1_blk;
    block_count_next = fold_blk ? '0 : cnt_inc;
    b_next.sum1_raw   = sum1_raw;
    b_next.sum1_final = fold(sum1_blk);
    b_next.fold_blk   = fold_blk;
    b_next.last       = last;
  end

  // first sum and block count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sum1        <= SumInit;
      block_count <= '0;
    end else if (in_take) begin
      sum1        <= sum1_next;
      block_count <= block_count_next;
    end
  end

  // stage register toward the second-sum unit
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_take) begin
      b_valid <= 1'b1;
    end else if (b_take) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      b <= b_next;
    end
  end

  fl32_sum2_stage u_sum2 (
    .clk       (clk),
    .rst       (rst),
    .b_valid   (b_valid),
    .b         (b),
    .b_take    (b_take),
    .checksum  (checksum),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
